[rtl/dsp_saturate_multiply_accumulate_macros.svh]
// ----------------------------------------------------------------------------
// DSP saturate/MAC assertion macros
// Shared concurrent assertion forms for the saturating MAC unit.
// ----------------------------------------------------------------------------
`ifndef DSP_SATURATE_MULTIPLY_ACCUMULATE_MACROS_SVH
`define DSP_SATURATE_MULTIPLY_ACCUMULATE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSMAC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSMAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dsmac_pkg.sv]
// ----------------------------------------------------------------------------
// DSP saturate/MAC package
// Opcodes, request and result types shared by the MAC unit.
// ----------------------------------------------------------------------------
package dsmac_pkg;

  localparam int WORD_W = 32;

  localparam logic [WORD_W-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] S32_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    OP_QADD  = 4'd0,
    OP_QSUB  = 4'd1,
    OP_QDADD = 4'd2,
    OP_QDSUB = 4'd3,
    OP_SMLA  = 4'd4,
    OP_SMLAW = 4'd5,
    OP_SMUL  = 4'd6,
    OP_SMULW = 4'd7,
    OP_SMLAL = 4'd8
  } opcode_t;

  typedef struct packed {
    logic [3:0]        opcode;
    logic              x_top;
    logic              y_top;
    logic [WORD_W-1:0] op_m;
    logic [WORD_W-1:0] op_n;
    logic [WORD_W-1:0] op_s;
    logic [WORD_W-1:0] acc_lo;
    logic [WORD_W-1:0] acc_hi;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_lo;
    logic [WORD_W-1:0] result_hi;
    logic              q_set;
  } rsp_t;

endpackage

[rtl/dsmac_in_if.sv]
// ----------------------------------------------------------------------------
// DSP saturate/MAC request channel
// Valid/ready channel carrying one DSP instruction request.
// ----------------------------------------------------------------------------
interface dsmac_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic        x_top;
  logic        y_top;
  logic [31:0] op_m;
  logic [31:0] op_n;
  logic [31:0] op_s;
  logic [31:0] acc_lo;
  logic [31:0] acc_hi;

  modport source (
    output valid, opcode, x_top, y_top, op_m, op_n, op_s, acc_lo, acc_hi,
    input  ready
  );

  modport sink (
    input  valid, opcode, x_top, y_top, op_m, op_n, op_s, acc_lo, acc_hi,
    output ready
  );
endinterface

[rtl/dsmac_out_if.sv]
// ----------------------------------------------------------------------------
// DSP saturate/MAC result channel
// Valid/ready channel carrying one 64-bit result and the Q flag request.
// ----------------------------------------------------------------------------
interface dsmac_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_lo;
  logic [31:0] result_hi;
  logic        q_set;

  modport source (
    output valid, result_lo, result_hi, q_set,
    input  ready
  );

  modport sink (
    input  valid, result_lo, result_hi, q_set,
    output ready
  );
endinterface

[rtl/dsp_saturate_multiply_accumulate.sv]
// ----------------------------------------------------------------------------
// DSP saturate/MAC unit
// Saturating add/sub and 16x16 / 32x16 multiply-accumulate execution unit.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Handshake          Payload
//  --------  ----  -----------------  ----------------------------------------
//  in_ch     in    valid/ready        opcode, x_top, y_top, op_m, op_n, op_s,
//                                     acc_lo, acc_hi
//  out_ch    out   valid/ready        result_lo, result_hi, q_set
//
//  One request per cycle sustained while out_ch.ready stays high. A taken
//  request sits in the input register, and its result moves into the result
//  register once that register is free; out_ch.valid is driven from the
//  result register, so it is registered after the input register.
//  Two register stages hold a request; the shared 32x16 multiplier and the
//  64-bit accumulate adder fit in the single pass between them.
//  Reset (rst_n low, synchronous) empties both stages; no other state exists.
//  A stalled result holds in the result register while the input register
//  still takes a new request; in_ch.ready drops only when both are full and
//  out_ch.ready is low.
//
module dsp_saturate_multiply_accumulate (
  input  logic        clk,
  input  logic        rst_n,
  dsmac_in_if.sink    in_ch,
  dsmac_out_if.source out_ch
);
  import dsmac_pkg::*;
  `include "dsp_saturate_multiply_accumulate_macros.svh"

  req_t in_req;
  req_t s1_req_r;
  req_t s1_req_nxt;
  logic s1_v_r;
  logic s1_v_nxt;
  rsp_t alu_rsp;
  rsp_t out_rsp_r;
  rsp_t out_rsp_nxt;
  logic out_v_r;
  logic out_v_nxt;
  logic out_free;
  logic s1_free;
  logic in_take;
  logic s1_move;

  always_comb begin
    in_req.opcode = in_ch.opcode;
    in_req.x_top  = in_ch.x_top;
    in_req.y_top  = in_ch.y_top;
    in_req.op_m   = in_ch.op_m;
    in_req.op_n   = in_ch.op_n;
    in_req.op_s   = in_ch.op_s;
    in_req.acc_lo = in_ch.acc_lo;
    in_req.acc_hi = in_ch.acc_hi;
  end

  // Flow control: result slot frees when empty or taken this cycle,
  // input slot frees when empty or moving into the result slot.
  always_comb begin
    out_free    = !out_v_r || out_ch.ready;
    s1_free     = !s1_v_r || out_free;
    in_take     = in_ch.valid && s1_free;
    s1_move     = s1_v_r && out_free;
    s1_v_nxt    = s1_free ? in_ch.valid : s1_v_r;
    s1_req_nxt  = in_take ? in_req : s1_req_r;
    out_v_nxt   = out_free ? s1_v_r : out_v_r;
    out_rsp_nxt = s1_move ? alu_rsp : out_rsp_r;
  end

  assign in_ch.ready = s1_free;

  dsmac_alu u_alu (
    .req (s1_req_r),
    .rsp (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_req_r  <= s1_req_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.result_lo = out_rsp_r.result_lo;
  assign out_ch.result_hi = out_rsp_r.result_hi;
  assign out_ch.q_set     = out_rsp_r.q_set;

  // Assertions
  `DSMAC_ASSERT_NEXT(a_take_fills_s1, clk, rst_n, in_take, s1_v_r,
    "accepted request did not land in input stage")
  `DSMAC_ASSERT_NEXT(a_move_fills_out, clk, rst_n, s1_move, out_v_r,
    "input stage moved but result register is empty")
  `DSMAC_ASSERT_SAME(a_hi_only_smlal, clk, rst_n,
    s1_v_r && (s1_req_r.opcode != OP_SMLAL), alu_rsp.result_hi == '0,
    "high result word nonzero for a non-long operation")
  `DSMAC_ASSERT_SAME(a_no_q_on_mul, clk, rst_n,
    s1_v_r && ((s1_req_r.opcode == OP_SMUL) || (s1_req_r.opcode == OP_SMULW) ||
    (s1_req_r.opcode == OP_SMLAL)), !alu_rsp.q_set,
    "Q flag requested by a plain multiply or long accumulate")

endmodule

[rtl/dsmac_alu.sv]
// ----------------------------------------------------------------------------
// DSP saturate/MAC datapath
// One shared 32x16 signed multiplier, saturating adder and accumulators.
// ----------------------------------------------------------------------------
module dsmac_alu (
  input  dsmac_pkg::req_t req,
  output dsmac_pkg::rsp_t rsp
);
  import dsmac_pkg::*;

  logic                     word_op;
  logic signed [15:0]       hx;
  logic signed [15:0]       hy;
  logic signed [WORD_W-1:0] mul_a;
  logic signed [47:0]       prod;
  logic [WORD_W-1:0]        mac_addend;
  logic [WORD_W:0]          mac_sum;
  logic                     mac_ovf;
  logic                     dbl_ovf;
  logic [WORD_W-1:0]        dbl_val;
  logic                     is_dbl;
  logic                     is_sub;
  logic [WORD_W-1:0]        sat_b;
  logic [WORD_W:0]          sat_sum;
  logic                     sat_ovf;
  logic [WORD_W-1:0]        sat_val;
  logic [2*WORD_W-1:0]      acc_sum;

  // Operand half selects, sign extended from bit 15.
  always_comb begin
    hx      = req.x_top ? req.op_m[31:16] : req.op_m[15:0];
    hy      = req.y_top ? req.op_s[31:16] : req.op_s[15:0];
    word_op = (req.opcode == OP_SMLAW) || (req.opcode == OP_SMULW);
    mul_a   = word_op ? req.op_m : {{16{hx[15]}}, hx};
    prod    = mul_a * hy;
  end

  // 32-bit accumulate with signed overflow detect, and 64-bit long accumulate.
  always_comb begin
    mac_addend = word_op ? prod[47:16] : prod[31:0];
    mac_sum    = {mac_addend[31], mac_addend} + {req.op_n[31], req.op_n};
    mac_ovf    = mac_sum[WORD_W] != mac_sum[WORD_W-1];
    acc_sum    = {req.acc_hi, req.acc_lo} + {{WORD_W{prod[31]}}, prod[31:0]};
  end

  // Saturating add/sub, with optional doubling of op_n.
  always_comb begin
    is_dbl  = (req.opcode == OP_QDADD) || (req.opcode == OP_QDSUB);
    is_sub  = (req.opcode == OP_QSUB) || (req.opcode == OP_QDSUB);
    dbl_ovf = req.op_n[31] != req.op_n[30];
    dbl_val = dbl_ovf ? (req.op_n[31] ? S32_MIN : S32_MAX) : {req.op_n[30:0], 1'b0};
    sat_b   = is_dbl ? dbl_val : req.op_n;
    sat_sum = is_sub ? ({req.op_m[31], req.op_m} - {sat_b[31], sat_b})
                     : ({req.op_m[31], req.op_m} + {sat_b[31], sat_b});
    sat_ovf = sat_sum[WORD_W] != sat_sum[WORD_W-1];
    sat_val = sat_ovf ? (sat_sum[WORD_W] ? S32_MIN : S32_MAX) : sat_sum[WORD_W-1:0];
  end

  always_comb begin
    rsp = '0;
    case (req.opcode)
      OP_QADD, OP_QSUB: begin
        rsp.result_lo = sat_val;
        rsp.q_set     = sat_ovf;
      end
      OP_QDADD, OP_QDSUB: begin
        rsp.result_lo = sat_val;
        rsp.q_set     = sat_ovf | dbl_ovf;
      end
      OP_SMLA, OP_SMLAW: begin
        rsp.result_lo = mac_sum[WORD_W-1:0];
        rsp.q_set     = mac_ovf;
      end
      OP_SMUL: begin
        rsp.result_lo = prod[31:0];
      end
      OP_SMULW: begin
        rsp.result_lo = prod[47:16];
      end
      OP_SMLAL: begin
        rsp.result_lo = acc_sum[WORD_W-1:0];
        rsp.result_hi = acc_sum[2*WORD_W-1:WORD_W];
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

endmodule
